// ===== rtl/mbfr_pkg.sv =====
`timescale 1ns / 1ps

package mbfr_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_CODE   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT = 4'd3;

    localparam logic [7:0]  RST_START_CODE  = 8'h68;
    localparam logic [7:0]  RST_TYPE_CODE   = 8'h20;
    localparam logic [7:0]  RST_END_CODE    = 8'h16;
    localparam logic [15:0] RST_GAP_TIMEOUT = 16'd100;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    localparam logic [1:0] ST_GOOD    = 2'd0;
    localparam logic [1:0] ST_CSUM    = 2'd1;
    localparam logic [1:0] ST_BAD_END = 2'd2;

    typedef enum logic [13:0] {
        PH_HUNT = 14'h0001,
        PH_TYPE = 14'h0002,
        PH_SER0 = 14'h0004,
        PH_SER1 = 14'h0008,
        PH_SER2 = 14'h0010,
        PH_SER3 = 14'h0020,
        PH_ADR0 = 14'h0040,
        PH_ADR1 = 14'h0080,
        PH_ADR2 = 14'h0100,
        PH_CTRL = 14'h0200,
        PH_LEN  = 14'h0400,
        PH_PAY  = 14'h0800,
        PH_CSUM = 14'h1000,
        PH_END  = 14'h2000
    } t_phase;

    typedef struct packed {
        logic [7:0]  start_code;
        logic [7:0]  type_code;
        logic [7:0]  end_code;
        logic [15:0] gap_timeout;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [1:0]  status;
        logic [7:0]  control_code;
        logic [7:0]  payload_length;
        logic [31:0] serial_number;
        logic [23:0] frame_address;
    } t_result;

endpackage

// ===== rtl/mbfr_parser.sv =====
`timescale 1ns / 1ps

module mbfr_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_op,
    input  logic [7:0]        i_data_byte,
    input  mbfr_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output mbfr_pkg::t_result o_res
);

    mbfr_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_remaining, n_remaining;
    logic [7:0]  r_position,  n_position;
    logic [7:0]  r_sum,       n_sum;
    logic [31:0] r_serial,    n_serial;
    logic [23:0] r_address,   n_address;
    logic [7:0]  r_control,   n_control;
    logic [7:0]  r_length,    n_length;
    logic        r_csum_ok,   n_csum_ok;
    logic [15:0] r_idle,      n_idle;

    logic             gap_expired;
    mbfr_pkg::t_phase cur_phase;
    logic [7:0]       cur_position;
    logic [7:0]       b;
    logic [7:0]       sum_plus;

    assign b            = i_data_byte;
    assign gap_expired  = (r_idle > i_cfg.gap_timeout);
    assign cur_phase    = gap_expired ? mbfr_pkg::PH_HUNT : r_phase;
    assign cur_position = gap_expired ? 8'd0 : r_position;
    assign sum_plus     = r_sum + b;

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_position  = r_position;
        n_sum       = r_sum;
        n_serial    = r_serial;
        n_address   = r_address;
        n_control   = r_control;
        n_length    = r_length;
        n_csum_ok   = r_csum_ok;
        n_idle      = r_idle;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_op == mbfr_pkg::OP_TICK) begin
            if (r_idle != 16'hFFFF) begin
                n_idle = r_idle + 16'd1;
            end
        end else begin
            n_phase    = cur_phase;
            n_position = cur_position;
            case (cur_phase)
                mbfr_pkg::PH_HUNT: begin
                    if (b == i_cfg.start_code) begin
                        n_sum      = b;
                        n_position = 8'd0;
                        n_idle     = 16'd0;
                        n_phase    = mbfr_pkg::PH_TYPE;
                    end
                end
                mbfr_pkg::PH_TYPE: begin
                    if (b == i_cfg.type_code) begin
                        n_sum   = sum_plus;
                        n_idle  = 16'd0;
                        n_phase = mbfr_pkg::PH_SER0;
                    end
                end
                mbfr_pkg::PH_SER0: begin
                    n_serial = {24'd0, b};
                    n_sum    = sum_plus;
                    n_idle   = 16'd0;
                    n_phase  = mbfr_pkg::PH_SER1;
                end
                mbfr_pkg::PH_SER1: begin
                    n_serial[15:8] = b;
                    n_sum          = sum_plus;
                    n_idle         = 16'd0;
                    n_phase        = mbfr_pkg::PH_SER2;
                end
                mbfr_pkg::PH_SER2: begin
                    n_serial[23:16] = b;
                    n_sum           = sum_plus;
                    n_idle          = 16'd0;
                    n_phase         = mbfr_pkg::PH_SER3;
                end
                mbfr_pkg::PH_SER3: begin
                    n_serial[31:24] = b;
                    n_sum           = sum_plus;
                    n_idle          = 16'd0;
                    n_phase         = mbfr_pkg::PH_ADR0;
                end
                mbfr_pkg::PH_ADR0: begin
                    n_address = {16'd0, b};
                    n_sum     = sum_plus;
                    n_idle    = 16'd0;
                    n_phase   = mbfr_pkg::PH_ADR1;
                end
                mbfr_pkg::PH_ADR1: begin
                    n_address[15:8] = b;
                    n_sum           = sum_plus;
                    n_idle          = 16'd0;
                    n_phase         = mbfr_pkg::PH_ADR2;
                end
                mbfr_pkg::PH_ADR2: begin
                    n_address[23:16] = b;
                    n_sum            = sum_plus;
                    n_idle           = 16'd0;
                    n_phase          = mbfr_pkg::PH_CTRL;
                end
                mbfr_pkg::PH_CTRL: begin
                    n_control = b;
                    n_sum     = sum_plus;
                    n_idle    = 16'd0;
                    n_phase   = mbfr_pkg::PH_LEN;
                end
                mbfr_pkg::PH_LEN: begin
                    n_length    = b;
                    n_remaining = b;
                    n_sum       = sum_plus;
                    n_idle      = 16'd0;
                    // skip the payload phase on an empty frame
                    n_phase     = (b != 8'd0) ? mbfr_pkg::PH_PAY : mbfr_pkg::PH_CSUM;
                end
                mbfr_pkg::PH_PAY: begin
                    o_res_valid         = 1'b1;
                    o_res.kind          = mbfr_pkg::KIND_PAYLOAD;
                    o_res.payload_byte  = b;
                    o_res.payload_index = cur_position;
                    n_position          = cur_position + 8'd1;
                    n_sum               = sum_plus;
                    n_idle              = 16'd0;
                    n_remaining         = r_remaining - 8'd1;
                    if (n_remaining == 8'd0) begin
                        n_phase = mbfr_pkg::PH_CSUM;
                    end
                end
                mbfr_pkg::PH_CSUM: begin
                    n_csum_ok = (b == r_sum);
                    n_idle    = 16'd0;
                    n_phase   = mbfr_pkg::PH_END;
                end
                mbfr_pkg::PH_END: begin
                    o_res_valid          = 1'b1;
                    o_res.kind           = mbfr_pkg::KIND_END;
                    if (b != i_cfg.end_code) begin
                        o_res.status = mbfr_pkg::ST_BAD_END;
                    end else begin
                        o_res.status = r_csum_ok ? mbfr_pkg::ST_GOOD : mbfr_pkg::ST_CSUM;
                    end
                    o_res.control_code   = r_control;
                    o_res.payload_length = r_length;
                    o_res.serial_number  = r_serial;
                    o_res.frame_address  = r_address;
                    n_idle               = 16'd0;
                    n_phase              = mbfr_pkg::PH_HUNT;
                end
                default: begin
                    n_phase = mbfr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mbfr_pkg::PH_HUNT;
            r_remaining <= 8'd0;
            r_position  <= 8'd0;
            r_sum       <= 8'd0;
            r_serial    <= 32'd0;
            r_address   <= 24'd0;
            r_control   <= 8'd0;
            r_length    <= 8'd0;
            r_csum_ok   <= 1'b0;
            r_idle      <= 16'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_position  <= n_position;
            r_sum       <= n_sum;
            r_serial    <= n_serial;
            r_address   <= n_address;
            r_control   <= n_control;
            r_length    <= n_length;
            r_csum_ok   <= n_csum_ok;
            r_idle      <= n_idle;
        end
    end

endmodule

// ===== rtl/meter_bus_frame_receiver_core.sv =====
`timescale 1ns / 1ps

// Meter bus frame receiver: takes one request per cycle, either a received byte or an
// idle tick, and walks the frame (start, type, serial, address, control, length,
// payload, checksum, end). Each payload byte yields one result; the end code position
// yields a frame report with status. A request is accepted every cycle while the single
// output register is empty or being drained that same cycle, so throughput is one
// request per clock and a result appears in the cycle after the request that caused it.
// The output register is the only thing that can stall the input side.
// Configuration writes take effect at once and must be made while no frame is in flight.
module meter_bus_frame_receiver_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_op,
    input  logic [7:0]                      i_data_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_kind,
    output logic [7:0]                      o_payload_byte,
    output logic [7:0]                      o_payload_index,
    output logic [1:0]                      o_status,
    output logic [7:0]                      o_control_code,
    output logic [7:0]                      o_payload_length,
    output logic [31:0]                     o_serial_number,
    output logic [23:0]                     o_frame_address,
    input  logic                            i_cfg_we,
    input  logic [mbfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    mbfr_pkg::t_cfg    r_cfg;
    mbfr_pkg::t_result r_out;
    mbfr_pkg::t_result res;
    logic              r_out_valid;
    logic              res_valid;
    logic              in_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_code  <= mbfr_pkg::RST_START_CODE;
            r_cfg.type_code   <= mbfr_pkg::RST_TYPE_CODE;
            r_cfg.end_code    <= mbfr_pkg::RST_END_CODE;
            r_cfg.gap_timeout <= mbfr_pkg::RST_GAP_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mbfr_pkg::REG_START_CODE:  r_cfg.start_code  <= i_cfg_data[7:0];
                mbfr_pkg::REG_TYPE_CODE:   r_cfg.type_code   <= i_cfg_data[7:0];
                mbfr_pkg::REG_END_CODE:    r_cfg.end_code    <= i_cfg_data[7:0];
                mbfr_pkg::REG_GAP_TIMEOUT: r_cfg.gap_timeout <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    mbfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= in_accept && res_valid;
        end
    end

    // load when an accepted request yields a result (register free or draining); hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_payload_index  = r_out.payload_index;
    assign o_status         = r_out.status;
    assign o_control_code   = r_out.control_code;
    assign o_payload_length = r_out.payload_length;
    assign o_serial_number  = r_out.serial_number;
    assign o_frame_address  = r_out.frame_address;

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && res_valid) |=> o_out_valid)
        else $error("accepted request with a result did not fill the output register");

    a_tick_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_op == mbfr_pkg::OP_TICK) |-> !res_valid)
        else $error("tick request produced a result");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == mbfr_pkg::KIND_PAYLOAD) |->
        (o_status == mbfr_pkg::ST_GOOD && o_control_code == 8'd0 &&
         o_serial_number == 32'd0 && o_frame_address == 24'd0))
        else $error("payload result carries frame report fields");

    a_report_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == mbfr_pkg::KIND_END) |->
        (o_payload_byte == 8'd0 && o_status != 2'd3))
        else $error("frame report malformed");

endmodule
